[design/assert_macros.svh]
// Assertion macros shared by the lift scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/lrs_pkg.sv]
// Types and constants of the lift request scheduler.
`timescale 1ns / 1ps
package lrs_pkg;

    // Field widths
    localparam int FLOOR_W    = 6;
    localparam int COUNT_W    = 6;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Floors reachable through a 6-bit floor number
    localparam int FLOOR_LIMIT = 64;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DENY_UP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DENY_DOWN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MOVED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd6;

    // Item modes
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWEST_FLOOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIDER_LIMIT   = 2'd2;

    // Configuration reset values
    localparam logic [FLOOR_W-1:0] RST_LOWEST_FLOOR  = 6'd0;
    localparam logic [FLOOR_W-1:0] RST_HIGHEST_FLOOR = 6'd15;
    localparam logic [COUNT_W-1:0] RST_RIDER_LIMIT   = 6'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the incoming item
        logic rd;      // read the per-floor count of the chosen floor
        logic reply;   // answer without touching the store
        logic commit;  // update the store and state, answer
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_mem; // item changes the store
    } t_sts;

endpackage

[design/lift_request_scheduler.sv]
// Top level of the lift request scheduler.
`timescale 1ns / 1ps
// One lift with direction-based scheduling. Raise start with mode and
// req_floor while busy is low; the item is taken at that edge. A denied
// request or an advance with no waiting rider is answered from the decide
// state; an accepted request or a move first does the registered read of the
// per-floor rider count memory. Each item gives one result, shown for exactly
// one cycle with o_strobe high; the receiver cannot stall, so it must take
// every strobed result. Configuration writes are always ready and belong
// between items. Reset clears the floor store at once through a flag per
// floor, so no clearing pass follows reset.
module lift_request_scheduler #(
    parameter int NUM_FLOORS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [lrs_pkg::FLOOR_W-1:0]       i_req_floor,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_strobe,
    output logic [lrs_pkg::STATUS_W-1:0]      o_status,
    output logic [lrs_pkg::FLOOR_W-1:0]       o_floor_now,
    output logic [lrs_pkg::COUNT_W-1:0]       o_occupants,
    output logic                              o_going_up,
    output logic [lrs_pkg::COUNT_W-1:0]       o_exited
);
    import lrs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration is accepted in every cycle
    assign o_cfg_ready = 1'b1;

    lrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    lrs_dp #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_req_floor  (i_req_floor),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_floor_now  (o_floor_now),
        .o_occupants  (o_occupants),
        .o_going_up   (o_going_up),
        .o_exited     (o_exited)
    );

endmodule

[design/lrs_ctrl.sv]
// Controller state machine of the lift request scheduler.
`timescale 1ns / 1ps
module lrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lrs_pkg::t_sts i_sts,
    output logic          o_busy,
    output lrs_pkg::t_cmd o_cmd
);
    import lrs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_mem) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EXEC;
                end else begin
                    o_cmd.reply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[design/lrs_dp.sv]
// Datapath of the lift request scheduler: registers, floor store, search.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrs_dp #(
    parameter int NUM_FLOORS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_mode,
    input  logic [lrs_pkg::FLOOR_W-1:0]       i_req_floor,
    input  lrs_pkg::t_cmd                     i_cmd,
    output lrs_pkg::t_sts                     o_sts,
    output logic                              o_strobe,
    output logic [lrs_pkg::STATUS_W-1:0]      o_status,
    output logic [lrs_pkg::FLOOR_W-1:0]       o_floor_now,
    output logic [lrs_pkg::COUNT_W-1:0]       o_occupants,
    output logic                              o_going_up,
    output logic [lrs_pkg::COUNT_W-1:0]       o_exited
);
    import lrs_pkg::*;

    localparam int DEPTH = (NUM_FLOORS < FLOOR_LIMIT) ? NUM_FLOORS : FLOOR_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] FLOOR_END = 9'(NUM_FLOORS);

    // Configuration registers
    logic [FLOOR_W-1:0] r_lowest;
    logic [FLOOR_W-1:0] r_highest;
    logic [COUNT_W-1:0] r_limit;

    // Latched item
    logic               r_mode;
    logic [FLOOR_W-1:0] r_dest;

    // Lift state; a flag per floor marks a nonzero stored count
    logic [COUNT_W-1:0] r_count;
    logic               r_up;
    logic [FLOOR_W-1:0] r_floor;
    logic [DEPTH-1:0]   r_flags;

    // Per-floor rider counts, read registered
    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rd;
    logic               r_rd_valid;
    logic [AW-1:0]      r_addr;

    // Result registers
    logic               r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [FLOOR_W-1:0] r_out_floor;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_up;
    logic [COUNT_W-1:0] r_out_exited;

    logic [STATUS_W-1:0] w_req_status;
    logic               s_hit;
    logic [AW-1:0]      s_target;
    logic [AW-1:0]      w_addr;
    logic [COUNT_W-1:0] w_stored;
    logic [FLOOR_W-1:0] w_tgt_floor;

    logic [COUNT_W-1:0] n_count;
    logic               n_up;
    logic [FLOOR_W-1:0] n_floor;
    logic [COUNT_W-1:0] n_mem_wr;
    logic [STATUS_W-1:0] n_status;
    logic [COUNT_W-1:0] n_exited;

    // Request checks, in order of precedence
    always_comb begin
        priority if (r_count >= r_limit) begin
            w_req_status = ST_FULL;
        end else if ((r_count != '0) && r_up && (r_dest < r_floor)) begin
            w_req_status = ST_DENY_UP;
        end else if ((r_count != '0) && !r_up && (r_dest > r_floor)) begin
            w_req_status = ST_DENY_DOWN;
        end else if ((r_dest < r_lowest) || (r_dest > r_highest)
                     || ({3'b000, r_dest} >= FLOOR_END)) begin
            w_req_status = ST_INVALID;
        end else begin
            w_req_status = ST_ACCEPT;
        end
    end

    // Next stop: lowest flagged floor going up, highest going down
    always_comb begin
        s_target = '0;
        if (r_up) begin
            for (int i = DEPTH - 1; i >= 0; i--) begin
                if (r_flags[i]) s_target = AW'(i);
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (r_flags[i]) s_target = AW'(i);
            end
        end
        s_hit = |r_flags;
    end

    assign o_sts.need_mem = (r_mode == MODE_ADVANCE) ? s_hit : (w_req_status == ST_ACCEPT);
    assign w_addr   = (r_mode == MODE_ADVANCE) ? s_target : r_dest[AW-1:0];
    assign w_stored = r_rd_valid ? r_rd : '0;
    assign w_tgt_floor = FLOOR_W'(r_addr);

    // Store and state update for a committed item
    always_comb begin
        n_count  = r_count;
        n_up     = r_up;
        n_floor  = r_floor;
        n_mem_wr = '0;
        n_status = ST_ACCEPT;
        n_exited = '0;
        if (r_mode == MODE_ADVANCE) begin
            n_status = ST_MOVED;
            n_exited = w_stored;
            n_count  = (w_stored >= r_count) ? '0 : r_count - w_stored;
            n_floor  = w_tgt_floor;
            if (w_tgt_floor == r_highest) begin
                n_up = 1'b0;
            end else if (w_tgt_floor == r_lowest) begin
                n_up = 1'b1;
            end
        end else begin
            n_count  = r_count + 6'd1;
            n_mem_wr = w_stored + 6'd1;
            if (r_count == '0) begin
                if (r_dest > r_floor) begin
                    n_up = 1'b1;
                end else if (r_dest < r_floor) begin
                    n_up = 1'b0;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= RST_LOWEST_FLOOR;
            r_highest <= RST_HIGHEST_FLOOR;
            r_limit   <= RST_RIDER_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOWEST_FLOOR:  r_lowest  <= i_cfg_data;
                REG_HIGHEST_FLOOR: r_highest <= i_cfg_data;
                REG_RIDER_LIMIT:   r_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_dest <= i_req_floor;
        end
    end

    // Floor store: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd   <= r_mem[w_addr];
            r_addr <= w_addr;
        end
        if (i_cmd.commit) begin
            r_mem[r_addr] <= n_mem_wr;
        end
    end

    // Lift state, flags and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_up       <= 1'b1;
            r_floor    <= '0;
            r_flags    <= '0;
            r_strobe   <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_strobe <= i_cmd.reply || i_cmd.commit;
            if (i_cmd.rd) begin
                r_rd_valid <= r_flags[w_addr];
            end
            if (i_cmd.commit) begin
                r_count         <= n_count;
                r_up            <= n_up;
                r_floor         <= n_floor;
                r_flags[r_addr] <= (n_mem_wr != '0);
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.reply) begin
            r_status     <= (r_mode == MODE_ADVANCE) ? ST_IDLE : w_req_status;
            r_out_floor  <= r_floor;
            r_out_count  <= r_count;
            r_out_up     <= r_up;
            r_out_exited <= '0;
        end else if (i_cmd.commit) begin
            r_status     <= n_status;
            r_out_floor  <= n_floor;
            r_out_count  <= n_count;
            r_out_up     <= n_up;
            r_out_exited <= n_exited;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_floor_now = r_out_floor;
    assign o_occupants = r_out_count;
    assign o_going_up  = r_out_up;
    assign o_exited    = r_out_exited;

    // Riders aboard exactly when some floor is flagged
    `ASSERT_ALWAYS(a_count_flags, i_clk, i_rst_n, (r_count == '0) == (r_flags == '0), "rider count and floor flags disagree")
    // A move empties exactly one floor
    `ASSERT_NEXT(a_move_clears, i_clk, i_rst_n, i_cmd.commit && (r_mode == MODE_ADVANCE), $countones(r_flags) + 1 == $past($countones(r_flags)), "move did not clear one floor")
    // An accepted request adds one rider
    `ASSERT_NEXT(a_req_adds, i_clk, i_rst_n, i_cmd.commit && (r_mode == MODE_REQUEST), r_count == 6'($past(r_count) + 6'd1), "accepted request did not add a rider")
    // Results never come in consecutive cycles
    `ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, r_strobe, !r_strobe, "results in consecutive cycles")

endmodule

[tb/tb_lift_request_scheduler.sv]
// Self-checking testbench for the lift request scheduler: directed table, then random phases.
`timescale 1ns / 1ps
module tb_lift_request_scheduler;
    import lrs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 115;

    // One result item of the block
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FLOOR_W-1:0]  floor_now;
        logic [COUNT_W-1:0]  occupants;
        logic                going_up;
        logic [COUNT_W-1:0]  exited;
    } t_lift_result;

    // Rows of the directed plan: either an item or a new set of limits
    typedef enum logic [0:0] {ROW_ITEM, ROW_LIMITS} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 mode;
        logic [FLOOR_W-1:0]   dest;
        logic [FLOOR_W-1:0]   lo;
        logic [FLOOR_W-1:0]   hi;
        logic [COUNT_W-1:0]   cap;
        logic                 known;
        t_lift_result         want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_mode = MODE_REQUEST;
    logic [FLOOR_W-1:0]    i_req_floor = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_LOWEST_FLOOR;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [FLOOR_W-1:0]    o_floor_now;
    logic [COUNT_W-1:0]    o_occupants;
    logic                  o_going_up;
    logic [COUNT_W-1:0]    o_exited;

    lift_request_scheduler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_req_floor  (i_req_floor),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_floor_now  (o_floor_now),
        .o_occupants  (o_occupants),
        .o_going_up   (o_going_up),
        .o_exited     (o_exited)
    );

    // Shadow of the lift: riders waiting per floor, cabin and limits
    logic [COUNT_W-1:0] sim_riders [FLOOR_LIMIT];
    logic [COUNT_W-1:0] sim_aboard;
    logic               sim_up;
    logic [FLOOR_W-1:0] sim_floor;
    logic [FLOOR_W-1:0] sim_lo;
    logic [FLOOR_W-1:0] sim_hi;
    logic [COUNT_W-1:0] sim_cap;

    t_lift_result due_results [$];
    t_plan_row    plan [$];
    t_lift_result front_result;

    int failures = 0;
    int cycles = 0;
    int items_sent = 0;
    int limit_sets = 0;
    int status_tally [8];
    logic burst_mode = 1'b0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycles,
                     due_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Next state of the lift for one item, and the result it gives
    function automatic t_lift_result scan_step(input logic mode, input logic [FLOOR_W-1:0] dest);
        t_lift_result res;
        int           target;
        int           i;
        res = '0;
        target = -1;
        if (mode == MODE_REQUEST) begin
            if (sim_aboard >= sim_cap)
                res.status = ST_FULL;
            else if (sim_aboard != 0 && sim_up && dest < sim_floor)
                res.status = ST_DENY_UP;
            else if (sim_aboard != 0 && !sim_up && dest > sim_floor)
                res.status = ST_DENY_DOWN;
            else if (dest < sim_lo || dest > sim_hi)
                res.status = ST_INVALID;
            else begin
                // first rider of an empty cabin picks the direction
                if (sim_aboard == 0) begin
                    if (dest > sim_floor)
                        sim_up = 1'b1;
                    else if (dest < sim_floor)
                        sim_up = 1'b0;
                end
                sim_aboard = sim_aboard + 6'd1;
                sim_riders[dest] = sim_riders[dest] + 6'd1;
                res.status = ST_ACCEPT;
            end
        end else begin
            // nearest waiting floor in the travel direction
            if (sim_up) begin
                for (i = 0; i < FLOOR_LIMIT; i++)
                    if (target < 0 && sim_riders[i] != 0)
                        target = i;
            end else begin
                for (i = FLOOR_LIMIT - 1; i >= 0; i--)
                    if (target < 0 && sim_riders[i] != 0)
                        target = i;
            end
            if (target < 0) begin
                res.status = ST_IDLE;
            end else begin
                res.exited = sim_riders[target];
                sim_riders[target] = '0;
                sim_aboard = (res.exited >= sim_aboard) ? '0 : sim_aboard - res.exited;
                sim_floor = target[FLOOR_W-1:0];
                if (sim_floor == sim_hi)
                    sim_up = 1'b0;
                else if (sim_floor == sim_lo)
                    sim_up = 1'b1;
                res.status = ST_MOVED;
            end
        end
        res.floor_now = sim_floor;
        res.occupants = sim_aboard;
        res.going_up  = sim_up;
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Result checker: the block answers in item order
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                $error("result with no item outstanding: status %0d floor %0d",
                       o_status, o_floor_now);
                failures++;
            end else begin
                front_result = due_results.pop_front();
                check_field("status", int'(front_result.status), int'(o_status));
                check_field("floor_now", int'(front_result.floor_now), int'(o_floor_now));
                check_field("occupants", int'(front_result.occupants), int'(o_occupants));
                check_field("going_up", int'(front_result.going_up), int'(o_going_up));
                check_field("exited", int'(front_result.exited), int'(o_exited));
                status_tally[o_status]++;
            end
        end
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic wait_all_answered();
        while (due_results.size() != 0)
            @(posedge i_clk);
        // allow for the longest item, one that reads the floor store
        repeat (4) @(posedge i_clk);
    endtask

    // Hand one item over; start stays high if the next item follows at once
    task automatic send_item(input logic mode, input logic [FLOOR_W-1:0] dest,
                             input logic known, input t_lift_result want, input int gap);
        t_lift_result predicted;
        start <= 1'b1;
        i_mode <= mode;
        i_req_floor <= dest;
        do @(posedge i_clk); while (busy);
        predicted = scan_step(mode, dest);
        if (known)
            predicted = want;
        due_results.insert(due_results.size(), predicted);
        items_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write all three limits while the lift is quiet
    task automatic program_limits(input logic [FLOOR_W-1:0] lo, input logic [FLOOR_W-1:0] hi,
                                  input logic [COUNT_W-1:0] cap);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        int                    k;
        idx[0] = REG_LOWEST_FLOOR;  val[0] = lo;
        idx[1] = REG_HIGHEST_FLOOR; val[1] = hi;
        idx[2] = REG_RIDER_LIMIT;   val[2] = cap;
        start <= 1'b0;
        wait_all_answered();
        for (k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        sim_lo = lo;
        sim_hi = hi;
        sim_cap = cap;
        limit_sets++;
    endtask

    // Mostly floors the lift will take, some anywhere
    function automatic logic [FLOOR_W-1:0] pick_floor();
        int lo_b;
        int hi_b;
        lo_b = int'(sim_lo);
        hi_b = int'(sim_hi);
        if ($urandom_range(0, 99) < 25 || lo_b > hi_b)
            return FLOOR_W'($urandom_range(0, FLOOR_LIMIT - 1));
        if (sim_aboard != 0) begin
            if (sim_up && int'(sim_floor) > lo_b)
                lo_b = int'(sim_floor);
            else if (!sim_up && int'(sim_floor) < hi_b)
                hi_b = int'(sim_floor);
        end
        if (lo_b > hi_b)
            return FLOOR_W'($urandom_range(0, FLOOR_LIMIT - 1));
        return FLOOR_W'($urandom_range(hi_b, lo_b));
    endfunction

    function automatic t_plan_row item_row(input logic mode, input logic [FLOOR_W-1:0] dest);
        t_plan_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.mode = mode;
        row.dest = dest;
        return row;
    endfunction

    function automatic t_plan_row known_row(input logic mode, input logic [FLOOR_W-1:0] dest,
                                            input logic [STATUS_W-1:0] status,
                                            input int floor_now, input int occupants,
                                            input int going_up, input int exited);
        t_plan_row row;
        row = item_row(mode, dest);
        row.known = 1'b1;
        row.want.status = status;
        row.want.floor_now = FLOOR_W'(floor_now);
        row.want.occupants = COUNT_W'(occupants);
        row.want.going_up = 1'(going_up);
        row.want.exited = COUNT_W'(exited);
        return row;
    endfunction

    function automatic t_plan_row limits_row(input int lo, input int hi, input int cap);
        t_plan_row row;
        row = '0;
        row.kind = ROW_LIMITS;
        row.lo = FLOOR_W'(lo);
        row.hi = FLOOR_W'(hi);
        row.cap = COUNT_W'(cap);
        return row;
    endfunction

    // Append one row to the directed plan
    function automatic void add_row(input t_plan_row row);
        plan.insert(plan.size(), row);
    endfunction

    // Stimulus
    initial begin
        int        n;
        int        p;
        int        lo;
        int        hi;
        int        cap;
        int        directed_items;
        t_plan_row row;

        for (n = 0; n < FLOOR_LIMIT; n++)
            sim_riders[n] = '0;
        for (n = 0; n < 8; n++)
            status_tally[n] = 0;
        sim_aboard = '0;
        sim_up = 1'b1;
        sim_floor = '0;
        sim_lo = RST_LOWEST_FLOOR;
        sim_hi = RST_HIGHEST_FLOOR;
        sim_cap = RST_RIDER_LIMIT;

        // reset limits: floors 0..15, 8 riders
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_IDLE, 0, 0, 1, 0));
        add_row(known_row(MODE_REQUEST, 6'd63, ST_INVALID, 0, 0, 1, 0));
        // first rider at the present floor keeps the direction
        add_row(known_row(MODE_REQUEST, 6'd0, ST_ACCEPT, 0, 1, 1, 0));
        add_row(known_row(MODE_REQUEST, 6'd15, ST_ACCEPT, 0, 2, 1, 0));
        add_row(known_row(MODE_ADVANCE, 6'd9, ST_MOVED, 0, 1, 1, 1));
        // top floor reached: turn down
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_MOVED, 15, 0, 0, 1));
        add_row(known_row(MODE_REQUEST, 6'd3, ST_ACCEPT, 15, 1, 0, 0));
        add_row(item_row(MODE_REQUEST, 6'd10));
        add_row(item_row(MODE_REQUEST, 6'd15));
        // against the direction is checked before the range
        add_row(known_row(MODE_REQUEST, 6'd20, ST_DENY_DOWN, 15, 3, 0, 0));
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_MOVED, 15, 2, 0, 1));
        add_row(item_row(MODE_ADVANCE, 6'd0));
        add_row(item_row(MODE_ADVANCE, 6'd0));
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_IDLE, 3, 0, 0, 0));
        add_row(item_row(MODE_REQUEST, 6'd8));
        add_row(known_row(MODE_REQUEST, 6'd1, ST_DENY_UP, 3, 1, 1, 0));
        // full range, one rider at a time
        add_row(limits_row(0, 63, 1));
        add_row(known_row(MODE_REQUEST, 6'd63, ST_FULL, 3, 1, 1, 0));
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_MOVED, 8, 0, 1, 1));
        add_row(known_row(MODE_REQUEST, 6'd63, ST_ACCEPT, 8, 1, 1, 0));
        add_row(known_row(MODE_REQUEST, 6'd0, ST_FULL, 8, 1, 1, 0));
        add_row(known_row(MODE_ADVANCE, 6'd0, ST_MOVED, 63, 0, 0, 1));
        // inverted range: nothing is a valid floor
        add_row(limits_row(63, 0, 63));
        add_row(known_row(MODE_REQUEST, 6'd0, ST_INVALID, 63, 0, 0, 0));
        add_row(known_row(MODE_REQUEST, 6'd42, ST_INVALID, 63, 0, 0, 0));
        add_row(known_row(MODE_REQUEST, 6'd21, ST_INVALID, 63, 0, 0, 0));
        add_row(known_row(MODE_ADVANCE, 6'd63, ST_IDLE, 63, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (plan[n]) begin
            row = plan[n];
            if (row.kind == ROW_LIMITS)
                program_limits(row.lo, row.hi, row.cap);
            else
                send_item(row.mode, row.dest, row.known, row.want, idle_gap());
        end
        directed_items = items_sent;

        // random phases, each under its own limits
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 6)
                0: begin lo = 0; hi = 63; cap = 63; end
                1: begin
                    lo = int'(RST_LOWEST_FLOOR);
                    hi = int'(RST_HIGHEST_FLOOR);
                    cap = int'(RST_RIDER_LIMIT);
                end
                2: begin
                    lo = $urandom_range(0, 31);
                    hi = lo + $urandom_range(0, 32);
                    cap = $urandom_range(1, 63);
                end
                3: begin
                    lo = $urandom_range(33, 63);
                    hi = $urandom_range(0, 32);
                    cap = $urandom_range(1, 63);
                end
                4: begin lo = $urandom_range(0, 63); hi = lo; cap = 1; end
                default: begin lo = $urandom_range(0, 20); hi = 63; cap = $urandom_range(2, 6); end
            endcase
            program_limits(FLOOR_W'(lo), FLOOR_W'(hi), COUNT_W'(cap));
            burst_mode = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // now and then let every answer come back first
                if ($urandom_range(0, 49) == 0) begin
                    start <= 1'b0;
                    wait_all_answered();
                end
                if ($urandom_range(0, 99) < 60)
                    send_item(MODE_REQUEST, pick_floor(), 1'b0, '0, idle_gap());
                else
                    send_item(MODE_ADVANCE, FLOOR_W'($urandom_range(0, FLOOR_LIMIT - 1)),
                              1'b0, '0, idle_gap());
            end
        end

        start <= 1'b0;
        wait_all_answered();
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            failures++;
        end

        $display("Ran %0d lift items (%0d from the directed table) under %0d sets of limits.",
                 items_sent, directed_items, limit_sets);
        $display("Seen: %0d accepted, %0d moves, %0d idle, %0d full, %0d denied, %0d invalid.",
                 status_tally[ST_ACCEPT], status_tally[ST_MOVED], status_tally[ST_IDLE],
                 status_tally[ST_FULL], status_tally[ST_DENY_UP] + status_tally[ST_DENY_DOWN],
                 status_tally[ST_INVALID]);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/lrs_pkg.sv
design/lrs_ctrl.sv
design/lrs_dp.sv
design/lift_request_scheduler.sv
tb/tb_lift_request_scheduler.sv
